FILE: sv/subset_sum_exhaustive_unit_macros.svh
// Assertion macros for the subset-sum search unit.
// Used by the top level; needs nothing else.
`ifndef SUBSET_SUM_EXHAUSTIVE_UNIT_MACROS_SVH
`define SUBSET_SUM_EXHAUSTIVE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sse_pkg.sv
// Shared constants and types for the subset-sum search unit.
// No dependencies.
package sse_pkg;

   localparam int IN_BITS              = 16;
   localparam int TARGET_BITS          = 20;
   localparam int DEFAULT_MAX_ELEMENTS = 16;
   localparam int DEFAULT_ELEMENT_BITS = 16;

   // One search step handed to the accumulator.
   typedef struct packed {
      logic clear;
      logic valid;
      logic add;
   } acc_step_type;

endpackage

FILE: sv/sse_req_if.sv
// Element channel of the subset-sum search unit.
// Depends on sse_pkg.
interface sse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sse_pkg::IN_BITS-1:0]   element_value;
   logic                                 last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

FILE: sv/sse_rsp_if.sv
// Result channel of the subset-sum search unit.
// No dependencies.
interface sse_rsp_if;
   logic valid;
   logic ready;
   logic subset_found;
   logic set_overflow;

   modport source (output valid, output subset_found, output set_overflow, input ready);
   modport sink   (input valid, input subset_found, input set_overflow, output ready);
endinterface

FILE: sv/subset_sum_exhaustive_unit.sv
// Subset-sum decision unit: loads signed elements, then walks all subsets in Gray order.
// Throughput: one element per cycle while loading; the search holds off input, one
// store read and one add or subtract per step. Stop early once the target is hit.
// Reset (synchronous, active high) clears the state, count, overflow flag, target and valids.
// Depends on sse_pkg, sse_req_if, sse_rsp_if, sse_ram, sse_accum and the macro header.
`include "subset_sum_exhaustive_unit_macros.svh"

module subset_sum_exhaustive_unit #(
   parameter int MAX_ELEMENTS = sse_pkg::DEFAULT_MAX_ELEMENTS,
   parameter int ELEMENT_BITS = sse_pkg::DEFAULT_ELEMENT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   sse_req_if.sink                           req_if,
   sse_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [sse_pkg::TARGET_BITS-1:0]   csr_wr_data
);

   localparam int ADDR_BITS = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DRAIN,
      S_DONE
   } state_type;

   // Control and datapath registers
   state_type                          state_ff, state_in;
   logic [CNT_BITS-1:0]                count_ff, count_in;
   logic                               ovf_ff, ovf_in;
   logic                               ovf_hold_ff, ovf_hold_in;
   logic [MAX_ELEMENTS-1:0]            step_ff, step_in;
   logic [MAX_ELEMENTS-1:0]            code_ff, code_in;
   logic [MAX_ELEMENTS-1:0]            limit_ff, limit_in;
   logic                               p_valid_ff, p_valid_in;
   logic                               p_add_ff, p_add_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic                               rsp_ovf_ff, rsp_ovf_in;
   logic signed [sse_pkg::TARGET_BITS-1:0] target_ff;

   // Combinational helpers
   logic                               accept;
   logic [CNT_BITS-1:0]                count_next;
   logic                               ovf_next;
   logic [MAX_ELEMENTS:0]              pow_w;
   logic [MAX_ELEMENTS-1:0]            step_onehot;
   logic [ADDR_BITS-1:0]               low_idx;
   logic [MAX_ELEMENTS-1:0]            code_flip;

   // RAM and accumulator connections
   logic                               wr_en;
   logic [ADDR_BITS-1:0]               wr_addr;
   logic [ELEMENT_BITS-1:0]            wr_data;
   logic                               rd_en;
   logic [ELEMENT_BITS-1:0]            rd_data;
   sse_pkg::acc_step_type              acc_step;
   logic                               acc_found;

   // Input side: take elements only between searches.
   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // Drop elements past the store depth; wrap or extend to the stored width.
   assign wr_en   = accept && (count_ff < CNT_BITS'(MAX_ELEMENTS));
   assign wr_addr = count_ff[ADDR_BITS-1:0];
   assign wr_data = ELEMENT_BITS'(req_if.element_value);

   assign count_next = (count_ff < CNT_BITS'(MAX_ELEMENTS)) ? CNT_BITS'(count_ff + 1'b1)
                                                            : count_ff;
   assign ovf_next   = ovf_ff | (count_ff >= CNT_BITS'(MAX_ELEMENTS));

   // Last step index: N low bits set.
   assign pow_w = (MAX_ELEMENTS + 1)'(1) << count_next;

   // Gray step: flip the lowest set bit of the step counter.
   assign step_onehot = step_ff & (~step_ff + MAX_ELEMENTS'(1));

   always_comb begin
      low_idx = '0;
      for (int k = MAX_ELEMENTS - 1; k >= 0; k--) begin
         if (step_ff[k]) begin
            low_idx = ADDR_BITS'(k);
         end
      end
   end

   assign code_flip = code_ff ^ step_onehot;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      ovf_hold_in  = ovf_hold_ff;
      step_in      = step_ff;
      code_in      = code_ff;
      limit_in     = limit_ff;
      p_valid_in   = 1'b0;
      p_add_in     = p_add_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      acc_step     = '{clear: 1'b0, valid: p_valid_ff, add: p_add_ff};

      // Retire the held result once the sink takes it.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_if.last_element) begin
                  // Freeze the set, start a fresh one, seed the empty subset.
                  count_in       = '0;
                  ovf_in         = 1'b0;
                  ovf_hold_in    = ovf_next;
                  limit_in       = MAX_ELEMENTS'(pow_w - 1'b1);
                  step_in        = MAX_ELEMENTS'(1);
                  code_in        = '0;
                  acc_step.clear = 1'b1;
                  state_in       = S_SEARCH;
               end else begin
                  count_in = count_next;
                  ovf_in   = ovf_next;
               end
            end
         end
         S_SEARCH: begin
            if (acc_found) begin
               // Hit: issue no further steps; the found flag is sticky.
               state_in = S_DONE;
            end else begin
               // Issue the read for this step; add or subtract lands next cycle.
               rd_en      = 1'b1;
               code_in    = code_flip;
               p_valid_in = 1'b1;
               p_add_in   = |(code_flip & step_onehot);
               step_in    = MAX_ELEMENTS'(step_ff + 1'b1);
               if (step_ff == limit_ff) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            // Last step accumulates this cycle.
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = acc_found;
               rsp_ovf_in   = ovf_hold_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ovf_hold_ff  <= ovf_hold_in;
      step_ff      <= step_in;
      code_ff      <= code_in;
      limit_ff     <= limit_in;
      p_add_ff     <= p_add_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.subset_found = rsp_found_ff;
   assign rsp_if.set_overflow = rsp_ovf_ff;

   // Element store
   sse_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (low_idx),
      .rd_data (rd_data)
   );

   // Running sum and compare
   sse_accum #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .step    (acc_step),
      .rd_data (rd_data),
      .target  (target_ff),
      .found   (acc_found)
   );

   `SSE_ASSERT_NEXT(a_last_starts_search, clock, reset, accept && req_if.last_element, state_ff == S_SEARCH, "last element did not start the search")
   `SSE_ASSERT_SAME(a_read_in_set, clock, reset, state_ff == S_SEARCH && !acc_found, (step_onehot & ~limit_ff) == '0, "search read beyond the stored elements")
   `SSE_ASSERT_SAME(a_step_nonzero, clock, reset, state_ff == S_SEARCH, step_ff != '0, "search step counter wrapped")
   `SSE_ASSERT_NEXT(a_issue_lands, clock, reset, state_ff == S_SEARCH && !acc_found, p_valid_ff, "issued step did not reach the accumulator")

endmodule

FILE: sv/sse_ram.sv
// Generic one-write, one-read RAM with a registered read port.
// No dependencies.
module sse_ram #(
   parameter  int WIDTH     = 16,
   parameter  int DEPTH     = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sse_accum.sv
// Running-sum accumulator and target compare for the subset search.
// Depends on sse_pkg.
module sse_accum #(
   parameter int MAX_ELEMENTS = sse_pkg::DEFAULT_MAX_ELEMENTS,
   parameter int ELEMENT_BITS = sse_pkg::DEFAULT_ELEMENT_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sse_pkg::acc_step_type                 step,
   input  logic signed [ELEMENT_BITS-1:0]        rd_data,
   input  logic signed [sse_pkg::TARGET_BITS-1:0] target,
   output logic                                  found
);

   // Exact sum of up to MAX_ELEMENTS elements, wide enough for the target too.
   localparam int SUM_BITS = ELEMENT_BITS + $clog2(MAX_ELEMENTS) + 1;
   localparam int CMP_BITS = (SUM_BITS > sse_pkg::TARGET_BITS) ? SUM_BITS
                                                                : sse_pkg::TARGET_BITS;

   logic signed [CMP_BITS-1:0] sum_ff, sum_in;
   logic signed [CMP_BITS-1:0] elem_ext, target_ext;
   logic                       found_ff, found_in;

   always_comb begin
      elem_ext   = CMP_BITS'(rd_data);
      target_ext = CMP_BITS'(target);
      sum_in     = sum_ff;
      found_in   = found_ff;
      if (step.clear) begin
         // Empty subset: sum zero.
         sum_in   = '0;
         found_in = (target_ext == '0);
      end else if (step.valid) begin
         sum_in   = step.add ? (sum_ff + elem_ext) : (sum_ff - elem_ext);
         found_in = found_ff | (sum_in == target_ext);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   assign found = found_ff;

endmodule

FILE: test/sse_verdict_checker.sv
// Result checker for the subset-sum search unit: mirrors the loaded set and the target,
// predicts one verdict per completed set and compares it with every result item.
// Depends on sse_pkg, sse_req_if and sse_rsp_if.
module sse_verdict_checker (
   input  logic                              clock,
   input  logic                              reset,
   sse_req_if                                req_mon,
   sse_rsp_if                                rsp_mon,
   input  logic                              csr_wr_en,
   input  logic [sse_pkg::TARGET_BITS-1:0]   csr_wr_data,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_DEPTH = sse_pkg::DEFAULT_MAX_ELEMENTS;

   typedef struct packed {
      logic subset_found;
      logic set_overflow;
   } verdict_type;

   logic signed [sse_pkg::IN_BITS-1:0]      set_elems [SET_DEPTH];
   int                                       set_size;
   logic                                     set_spilled;
   logic signed [sse_pkg::TARGET_BITS-1:0]  target_sum;
   verdict_type                              verdict_q [$];

   // Walk every subset of the held elements in Gray order, one add or subtract per step.
   function automatic logic subset_hits_target();
      int          acc;
      int unsigned code;
      int unsigned step;
      int          b;
      acc  = 0;
      code = 0;
      if (acc == target_sum) return 1'b1;
      for (step = 1; step < (32'd1 << set_size); step++) begin
         b = 0;
         while (step[b] == 1'b0) b++;
         code ^= (32'd1 << b);
         if (code[b]) acc += set_elems[b];
         else acc -= set_elems[b];
         if (acc == target_sum) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t sse_verdict_checker: %s: got %0d, want %0d", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         set_size    = 0;
         set_spilled = 1'b0;
         target_sum  = '0;
         verdict_q.delete();
      end else begin
         if (csr_wr_en) target_sum = csr_wr_data;

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("result item with no set pending", rsp_mon.subset_found, -1);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_mon.subset_found !== want.subset_found)
                  report_mismatch("subset_found", rsp_mon.subset_found, want.subset_found);
               if (rsp_mon.set_overflow !== want.set_overflow)
                  report_mismatch("set_overflow", rsp_mon.set_overflow, want.set_overflow);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (set_size < SET_DEPTH) begin
               set_elems[set_size] = req_mon.element_value;
               set_size++;
            end else begin
               set_spilled = 1'b1;
            end
            if (req_mon.last_element) begin
               want.subset_found = subset_hits_target();
               want.set_overflow = set_spilled;
               verdict_q = {verdict_q, want};
               set_size    = 0;
               set_spilled = 1'b0;
            end
         end
      end
      pending = verdict_q.size();
   end

endmodule

FILE: test/tb.sv
// Testbench top for the subset-sum search unit: drives element sets and target writes
// and gives the verdict; prediction and comparison sit in sse_verdict_checker.
// Depends on sse_pkg, sse_req_if, sse_rsp_if, subset_sum_exhaustive_unit and the checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SET_DEPTH       = sse_pkg::DEFAULT_MAX_ELEMENTS;
   localparam int     DIRECTED_ITEMS  = 25;
   localparam int     RANDOM_ITEMS    = 625;
   localparam int     RSP_HOLD_CYCLES = 300;
   localparam int     SETTLE_CYCLES   = 64;
   localparam longint TIMEOUT_NS      = 150_000_000;

   typedef logic signed [sse_pkg::IN_BITS-1:0]     elem_type;
   typedef logic signed [sse_pkg::TARGET_BITS-1:0] target_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [sse_pkg::TARGET_BITS-1:0] csr_wr_data;

   int         fail_count;
   int         pending;
   int         send_idle_pct = 24;
   int         recv_idle_pct = 86;
   bit         rsp_hold_req  = 1'b0;
   int         items_sent    = 0;
   target_type cur_target    = '0;

   sse_req_if req_if ();
   sse_rsp_if rsp_if ();

   subset_sum_exhaustive_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sse_verdict_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run well past the slowest legal schedule of full 16-element searches.
   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off once the stimulus asks for
   // it, so results back up inside the block and it stops taking elements.
   initial begin
      int hold_left;
      hold_left    = RSP_HOLD_CYCLES;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req && hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one element; idle cycles carry junk payload with valid low.
   task automatic send_element(input elem_type value, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid         <= 1'b0;
         req_if.element_value <= elem_type'($urandom);
         req_if.last_element  <= 1'($urandom);
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.element_value <= value;
      req_if.last_element  <= last;
      // Wait for the block to take it.
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and hold until every predicted result has been taken, then let the
   // search engine settle.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the target only with the block idle.
   task automatic write_target(input target_type value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_target   = value;
   endtask

   initial begin
      elem_type   set_q [$];
      target_type next_target;
      int         set_total;
      int         set_count;
      int         phase_sets;
      int         style;
      int         pick;
      int         draw;
      int         partial;
      int         k;
      int         j;
      bit         squeeze;
      bit         pressure_done;
      logic [SET_DEPTH-1:0] mask;

      // Drive every input to a known value from time zero.
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_if.valid         = 1'b0;
      req_if.element_value = '0;
      req_if.last_element  = 1'b0;
      pressure_done        = 1'b0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // ---- Directed sets ----
      // Target still at its reset value of zero: the empty subset always counts.
      send_element(16'sd5, 1'b1);

      // Seventeen ones against 17: the seventeenth is dropped, so the full 16-element
      // search misses and the overflow flag comes back set.
      write_target(target_type'(17));
      for (k = 0; k < 17; k++) send_element(16'sd1, k == 16);

      // Most negative target against the most negative element: miss.
      write_target(target_type'(-524288));
      send_element(elem_type'(-32768), 1'b1);

      // Both element extremes together reach -1.
      write_target(target_type'(-1));
      send_element(elem_type'(32767), 1'b0);
      send_element(elem_type'(-32768), 1'b1);

      // Most positive target is out of reach of a single element.
      write_target(target_type'(524287));
      send_element(elem_type'(32767), 1'b1);

      // Hit by a proper, non-contiguous subset.
      write_target(target_type'(100));
      send_element(16'sd40, 1'b0);
      send_element(16'sd70, 1'b0);
      send_element(16'sd60, 1'b1);

      // ---- Random phases: one target write, then a burst of sets back to back ----
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         // Advance through the idle regimes by progress.
         if (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 86;
         end else if (items_sent < DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 86;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // Pick a target: mostly small or mid-range so hits are common, with full-width
         // random values and the extremes mixed in.
         pick = $urandom_range(99);
         if (pick < 35) begin
            draw        = int'($urandom_range(24)) - 12;
            next_target = target_type'(draw);
         end else if (pick < 60) begin
            next_target = target_type'($urandom);
         end else if (pick < 75) begin
            case ($urandom_range(6))
               0: begin
                  next_target = target_type'(-524288);
               end
               1: begin
                  next_target = target_type'(524287);
               end
               2: begin
                  next_target = target_type'(0);
               end
               3: begin
                  next_target = target_type'(-1);
               end
               4: begin
                  next_target = target_type'(1);
               end
               5: begin
                  next_target = target_type'(32767);
               end
               default: begin
                  next_target = target_type'(-32768);
               end
            endcase
         end else begin
            draw        = int'($urandom_range(140000)) - 70000;
            next_target = target_type'(draw);
         end
         write_target(next_target);

         // Once, stall the result side for a long stretch while small sets keep coming.
         squeeze = 1'b0;
         if (!pressure_done && items_sent >= 200) begin
            pressure_done = 1'b1;
            squeeze       = 1'b1;
            rsp_hold_req  = 1'b1;
            phase_sets    = 6;
         end else begin
            phase_sets = $urandom_range(1, 6);
         end

         for (set_count = 0; set_count < phase_sets; set_count++) begin
            // Keep most sets small; the search time doubles per element.
            pick = $urandom_range(99);
            if (squeeze || pick < 70) set_total = $urandom_range(1, 5);
            else if (pick < 90) set_total = $urandom_range(6, 9);
            else if (pick < 96) set_total = $urandom_range(10, 12);
            else if (pick < 98) set_total = $urandom_range(13, 16);
            else set_total = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 3);

            style = $urandom_range(2);
            set_q.delete();
            for (k = 0; k < set_total; k++) begin
               case (style)
                  0: begin
                     draw = int'($urandom_range(16)) - 8;
                  end
                  1: begin
                     draw = int'(elem_type'($urandom));
                  end
                  default: begin
                     case ($urandom_range(3))
                        0:       draw = -32768;
                        1:       draw = 32767;
                        2:       draw = 0;
                        default: draw = int'(elem_type'($urandom));
                     endcase
                  end
               endcase
               set_q = {set_q, elem_type'(draw)};
            end

            // Plant a hit in some sets: pick a subset among the stored elements and fix
            // one member so the subset sums to the target, when that fits in an element.
            if ($urandom_range(99) < 40) begin
               mask    = SET_DEPTH'($urandom);
               j       = $urandom_range(((set_total < SET_DEPTH) ? set_total : SET_DEPTH) - 1);
               mask[j] = 1'b1;
               partial = 0;
               for (k = 0; k < set_total && k < SET_DEPTH; k++) begin
                  if (mask[k] && k != j) partial += set_q[k];
               end
               draw = int'(cur_target) - partial;
               if (draw >= -32768 && draw <= 32767) set_q[j] = elem_type'(draw);
            end

            for (k = 0; k < set_total; k++) send_element(set_q[k], k == set_total - 1);
         end
      end

      // Hold until every result is in, then watch a while for strays.
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
